// ----- hw/rtl/sphull_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_pkg
// Shared constants, types and the controller/datapath command and status
// structures of the polygon hull core.
// ---------------------------------------------------------------------------
package sphull_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int DEQ_DEPTH    = 128;
    localparam int IDX_BITS     = $clog2(DEQ_DEPTH);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int K_BITS       = $clog2(MAX_VERTICES + 1);
    localparam int SIZE_BITS    = 7;
    localparam int PT_BITS      = 2 * COORD_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef enum logic [1:0] {
        ST_HULL      = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_FEW       = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RD_TNEAR,
        RD_TOP,
        RD_BOT,
        RD_BOT1,
        RD_EMIT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_S0,
        WR_S1,
        WR_S2,
        WR_S3,
        WR_TOP,
        WR_BOT
    } wr_sel_t;

    typedef enum logic [2:0] {
        OPS_NONE,
        OPS_COL,
        OPS_SEED,
        OPS_WRAP0,
        OPS_WRAP1
    } ops_t;

    typedef struct packed {
        logic    latch_in;
        rd_sel_t rd_sel;
        logic    ld_a;
        logic    ld_b;
        logic    ld_c_p;
        ops_t    ops;
        logic    ori_start;
        logic    save_neg;
        logic    set_col;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    seed_idx;
        logic    top_inc;
        logic    top_dec;
        logic    bot_inc;
        logic    bot_dec;
        logic    advance;
        logic    clear_run;
        logic    emit_rst;
        logic    emit_inc;
        logic    out_ld_pt;
        logic    out_ld_status;
        status_t status_code;
    } cmd_t;

    typedef struct packed {
        logic k_lt2;
        logic k_eq2;
        logic k_full;
        logic n_lt3;
        logic fin;
        logic deq_ge3;
        logic size_bad;
        logic emit_last;
        logic col_seen;
        logic neg_flag;
        logic ori_done;
        logic s_pos;
        logic s_neg;
        logic s_zero;
    } stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sphull_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_ifs
// Vertex request channel and hull result channel (valid/ready).
// ---------------------------------------------------------------------------
interface sphull_vtx_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [sphull_pkg::COORD_BITS-1:0] point_x;
    logic signed [sphull_pkg::COORD_BITS-1:0] point_y;
    logic                                    final_vertex;

    modport source (output valid, point_x, point_y, final_vertex, input ready);
    modport sink   (input valid, point_x, point_y, final_vertex, output ready);
endinterface

interface sphull_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [sphull_pkg::COORD_BITS-1:0] hull_x;
    logic signed [sphull_pkg::COORD_BITS-1:0] hull_y;
    logic [1:0]                              status;
    logic [sphull_pkg::SIZE_BITS-1:0]        hull_size;
    logic                                    last_result;

    modport source (output valid, hull_x, hull_y, status, hull_size, last_result,
                    input ready);
    modport sink   (input valid, hull_x, hull_y, status, hull_size, last_result,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sphull_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sphull_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sphull_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_dp
// Datapath: vertex registers, deque indices and store, orientation pipeline
// and the result register.
// ---------------------------------------------------------------------------
module sphull_dp (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire sphull_pkg::cmd_t                         cmd,
    output sphull_pkg::stat_t                             stat,
    input  wire logic signed [sphull_pkg::COORD_BITS-1:0] in_x,
    input  wire logic signed [sphull_pkg::COORD_BITS-1:0] in_y,
    input  wire logic                                     in_final,
    output logic signed [sphull_pkg::COORD_BITS-1:0]      hull_x,
    output logic signed [sphull_pkg::COORD_BITS-1:0]      hull_y,
    output logic [1:0]                                    status,
    output logic [sphull_pkg::SIZE_BITS-1:0]              hull_size,
    output logic                                          last_result
);

    localparam int C  = sphull_pkg::COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int SW = 2 * C + 3;
    localparam int IW = sphull_pkg::IDX_BITS;
    localparam int NW = sphull_pkg::CNT_BITS;
    localparam int KW = sphull_pkg::K_BITS;

    sphull_pkg::point_t p_reg, first0_reg, first1_reg, prev0_reg, prev1_reg;
    sphull_pkg::point_t a_reg, b_reg, c_reg, rd_pt, wr_pt;
    logic               fin_reg, col_reg, neg_reg;
    logic [KW-1:0]      k_reg;
    logic [IW-1:0]      top_reg, bot_reg, j_reg;
    logic [IW-1:0]      raddr, waddr;
    logic [sphull_pkg::PT_BITS-1:0] rdata;
    logic [NW-1:0]      cnt;

    logic signed [DW-1:0] dy1_reg, dx2_reg, dy2_reg, dx1_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [SW-1:0] diff;
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 pos_reg, neg_s_reg, zero_reg;

    assign rd_pt = sphull_pkg::point_t'(rdata);
    assign cnt   = {1'b0, top_reg - bot_reg} + NW'(1);

    // deque store addressing
    always_comb
    begin
        case (cmd.rd_sel)
            sphull_pkg::RD_TNEAR: raddr = top_reg - IW'(1);
            sphull_pkg::RD_TOP:   raddr = top_reg;
            sphull_pkg::RD_BOT:   raddr = bot_reg;
            sphull_pkg::RD_BOT1:  raddr = bot_reg + IW'(1);
            sphull_pkg::RD_EMIT:  raddr = bot_reg + j_reg;
            default:              raddr = top_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            sphull_pkg::WR_S0:
            begin
                waddr = IW'(0);
                wr_pt = p_reg;
            end
            sphull_pkg::WR_S1:
            begin
                waddr = IW'(1);
                wr_pt = neg_reg ? first0_reg : first1_reg;
            end
            sphull_pkg::WR_S2:
            begin
                waddr = IW'(2);
                wr_pt = neg_reg ? first1_reg : first0_reg;
            end
            sphull_pkg::WR_S3:
            begin
                waddr = IW'(3);
                wr_pt = p_reg;
            end
            sphull_pkg::WR_TOP:
            begin
                waddr = top_reg + IW'(1);
                wr_pt = p_reg;
            end
            sphull_pkg::WR_BOT:
            begin
                waddr = bot_reg - IW'(1);
                wr_pt = p_reg;
            end
            default:
            begin
                waddr = top_reg;
                wr_pt = p_reg;
            end
        endcase
    end

    sphull_ram #(
        .WIDTH (sphull_pkg::PT_BITS),
        .DEPTH (sphull_pkg::DEQ_DEPTH)
    ) u_deque (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wr_pt),
        .raddr (raddr),
        .rdata (rdata)
    );

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= '0;
            top_reg    <= '0;
            bot_reg    <= '0;
            col_reg    <= 1'b0;
            first0_reg <= '0;
            first1_reg <= '0;
            prev0_reg  <= '0;
            prev1_reg  <= '0;
        end
        else if (cmd.clear_run)
        begin
            k_reg      <= '0;
            top_reg    <= '0;
            bot_reg    <= '0;
            col_reg    <= 1'b0;
            first0_reg <= '0;
            first1_reg <= '0;
            prev0_reg  <= '0;
            prev1_reg  <= '0;
        end
        else
        begin
            if (cmd.set_col)
            begin
                col_reg <= 1'b1;
            end
            if (cmd.seed_idx)
            begin
                top_reg <= IW'(3);
                bot_reg <= '0;
            end
            if (cmd.top_inc)
            begin
                top_reg <= top_reg + IW'(1);
            end
            if (cmd.top_dec)
            begin
                top_reg <= top_reg - IW'(1);
            end
            if (cmd.bot_inc)
            begin
                bot_reg <= bot_reg + IW'(1);
            end
            if (cmd.bot_dec)
            begin
                bot_reg <= bot_reg - IW'(1);
            end
            if (cmd.advance)
            begin
                prev0_reg <= prev1_reg;
                prev1_reg <= p_reg;
                if (k_reg == KW'(0))
                begin
                    first0_reg <= p_reg;
                end
                if (k_reg == KW'(1))
                begin
                    first1_reg <= p_reg;
                end
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            p_reg.x <= in_x;
            p_reg.y <= in_y;
            fin_reg <= in_final;
        end
        if (cmd.save_neg)
        begin
            neg_reg <= neg_s_reg;
        end
        if (cmd.ld_a)
        begin
            a_reg <= rd_pt;
        end
        if (cmd.ld_b)
        begin
            b_reg <= rd_pt;
        end
        if (cmd.ld_c_p)
        begin
            c_reg <= p_reg;
        end
        case (cmd.ops)
            sphull_pkg::OPS_COL:
            begin
                a_reg <= prev0_reg;
                b_reg <= prev1_reg;
                c_reg <= p_reg;
            end
            sphull_pkg::OPS_SEED:
            begin
                a_reg <= first0_reg;
                b_reg <= first1_reg;
                c_reg <= p_reg;
            end
            sphull_pkg::OPS_WRAP0:
            begin
                a_reg <= prev0_reg;
                b_reg <= prev1_reg;
                c_reg <= first0_reg;
            end
            sphull_pkg::OPS_WRAP1:
            begin
                a_reg <= prev1_reg;
                b_reg <= first0_reg;
                c_reg <= first1_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.emit_rst)
        begin
            j_reg <= '0;
        end
        if (cmd.emit_inc)
        begin
            j_reg <= j_reg + IW'(1);
        end
        if (cmd.out_ld_pt)
        begin
            hull_x      <= rd_pt.x;
            hull_y      <= rd_pt.y;
            status      <= sphull_pkg::ST_HULL;
            hull_size   <= sphull_pkg::SIZE_BITS'(cnt - NW'(1));
            last_result <= stat.emit_last;
        end
        if (cmd.out_ld_status)
        begin
            hull_x      <= '0;
            hull_y      <= '0;
            status      <= cmd.status_code;
            hull_size   <= '0;
            last_result <= 1'b1;
        end
        // orientation: differences, products, sign
        dy1_reg <= {b_reg.y[C-1], b_reg.y} - {a_reg.y[C-1], a_reg.y};
        dx2_reg <= {c_reg.x[C-1], c_reg.x} - {b_reg.x[C-1], b_reg.x};
        dy2_reg <= {c_reg.y[C-1], c_reg.y} - {b_reg.y[C-1], b_reg.y};
        dx1_reg <= {b_reg.x[C-1], b_reg.x} - {a_reg.x[C-1], a_reg.x};
        m1_reg  <= dy1_reg * dx2_reg;
        m2_reg  <= dy2_reg * dx1_reg;
        pos_reg   <= !diff[SW-1] && (diff != '0);
        neg_s_reg <= diff[SW-1];
        zero_reg  <= (diff == '0);
    end

    assign diff = {m1_reg[PW-1], m1_reg} - {m2_reg[PW-1], m2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.ori_start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        stat.k_lt2     = k_reg < KW'(2);
        stat.k_eq2     = k_reg == KW'(2);
        stat.k_full    = k_reg >= KW'(sphull_pkg::MAX_VERTICES);
        stat.n_lt3     = k_reg < KW'(3);
        stat.fin       = fin_reg;
        stat.deq_ge3   = cnt >= NW'(3);
        stat.size_bad  = (cnt < NW'(3)) || ((cnt - NW'(1)) > NW'(sphull_pkg::MAX_VERTICES));
        stat.emit_last = ({1'b0, j_reg} + NW'(2)) == cnt;
        stat.col_seen  = col_reg;
        stat.neg_flag  = neg_reg;
        stat.ori_done  = v3_reg;
        stat.s_pos     = pos_reg;
        stat.s_neg     = neg_s_reg;
        stat.s_zero    = zero_reg;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sphull_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_ctrl
// Sequencer: per-vertex collinear test, seeding, the two Melkman trim loops,
// the closing wrap-around tests and result emission.
// ---------------------------------------------------------------------------
module sphull_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire sphull_pkg::stat_t stat,
    output sphull_pkg::cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_FETCH0, S_FETCH1, S_FETCH2, S_ORI, S_WAIT,
        S_SEED0, S_SEED1, S_SEED2, S_SEED3, S_TOPCHK, S_PUSHT, S_BOTCHK,
        S_PUSHB, S_ADV, S_FIN, S_DECIDE, S_EMRD, S_EMLD, S_EMOUT, S_STOUT,
        S_CLEAR
    } state_t;

    typedef enum logic [2:0] {
        K_COL, K_SEED, K_SKIPT, K_SKIPB, K_POPT, K_POPB, K_WRAP0, K_WRAP1
    } kind_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   pair_top_reg, pair_top_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        kind_next      = kind_reg;
        pair_top_next  = pair_top_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.k_full)
                begin
                    state_next = stat.fin ? S_FIN : S_IDLE;
                end
                else if (stat.k_lt2)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.ops    = sphull_pkg::OPS_COL;
                    kind_next  = K_COL;
                    state_next = S_ORI;
                end
            end
            S_FETCH0:
            begin
                cmd.rd_sel = pair_top_reg ? sphull_pkg::RD_TNEAR : sphull_pkg::RD_BOT;
                state_next = S_FETCH1;
            end
            S_FETCH1:
            begin
                cmd.rd_sel = pair_top_reg ? sphull_pkg::RD_TOP : sphull_pkg::RD_BOT1;
                cmd.ld_a   = 1'b1;
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                cmd.ld_b   = 1'b1;
                cmd.ld_c_p = 1'b1;
                state_next = S_ORI;
            end
            S_ORI:
            begin
                cmd.ori_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.ori_done)
                begin
                    case (kind_reg)
                        K_COL:
                        begin
                            cmd.set_col = stat.s_zero;
                            if (stat.k_eq2)
                            begin
                                cmd.ops    = sphull_pkg::OPS_SEED;
                                kind_next  = K_SEED;
                                state_next = S_ORI;
                            end
                            else
                            begin
                                pair_top_next = 1'b1;
                                kind_next     = K_SKIPT;
                                state_next    = S_FETCH0;
                            end
                        end
                        K_SEED:
                        begin
                            cmd.save_neg = 1'b1;
                            state_next   = S_SEED0;
                        end
                        K_SKIPT:
                        begin
                            cmd.save_neg  = 1'b1;
                            pair_top_next = 1'b0;
                            kind_next     = K_SKIPB;
                            state_next    = S_FETCH0;
                        end
                        K_SKIPB:
                        begin
                            // inside both hull edges: vertex cannot change the hull
                            state_next = (stat.neg_flag && stat.s_neg) ? S_ADV : S_TOPCHK;
                        end
                        K_POPT:
                        begin
                            cmd.top_dec = stat.s_pos;
                            state_next  = stat.s_pos ? S_TOPCHK : S_PUSHT;
                        end
                        K_POPB:
                        begin
                            cmd.bot_inc = stat.s_pos;
                            state_next  = stat.s_pos ? S_BOTCHK : S_PUSHB;
                        end
                        K_WRAP0:
                        begin
                            cmd.set_col = stat.s_zero;
                            cmd.ops     = sphull_pkg::OPS_WRAP1;
                            kind_next   = K_WRAP1;
                            state_next  = S_ORI;
                        end
                        K_WRAP1:
                        begin
                            cmd.set_col = stat.s_zero;
                            state_next  = S_DECIDE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEED0:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sphull_pkg::WR_S0;
                state_next = S_SEED1;
            end
            S_SEED1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sphull_pkg::WR_S1;
                state_next = S_SEED2;
            end
            S_SEED2:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = sphull_pkg::WR_S2;
                state_next = S_SEED3;
            end
            S_SEED3:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = sphull_pkg::WR_S3;
                cmd.seed_idx = 1'b1;
                state_next   = S_ADV;
            end
            S_TOPCHK:
            begin
                if (stat.deq_ge3)
                begin
                    pair_top_next = 1'b1;
                    kind_next     = K_POPT;
                    state_next    = S_FETCH0;
                end
                else
                begin
                    state_next = S_PUSHT;
                end
            end
            S_PUSHT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = sphull_pkg::WR_TOP;
                cmd.top_inc = 1'b1;
                state_next  = S_BOTCHK;
            end
            S_BOTCHK:
            begin
                if (stat.deq_ge3)
                begin
                    pair_top_next = 1'b0;
                    kind_next     = K_POPB;
                    state_next    = S_FETCH0;
                end
                else
                begin
                    state_next = S_PUSHB;
                end
            end
            S_PUSHB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = sphull_pkg::WR_BOT;
                cmd.bot_dec = 1'b1;
                state_next  = S_ADV;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = stat.fin ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (stat.n_lt3)
                begin
                    cmd.out_ld_status = 1'b1;
                    cmd.status_code   = sphull_pkg::ST_FEW;
                    out_valid_next    = 1'b1;
                    state_next        = S_STOUT;
                end
                else
                begin
                    cmd.ops    = sphull_pkg::OPS_WRAP0;
                    kind_next  = K_WRAP0;
                    state_next = S_ORI;
                end
            end
            S_DECIDE:
            begin
                if (stat.col_seen)
                begin
                    cmd.out_ld_status = 1'b1;
                    cmd.status_code   = sphull_pkg::ST_COLLINEAR;
                    out_valid_next    = 1'b1;
                    state_next        = S_STOUT;
                end
                else if (stat.size_bad)
                begin
                    cmd.out_ld_status = 1'b1;
                    cmd.status_code   = sphull_pkg::ST_FEW;
                    out_valid_next    = 1'b1;
                    state_next        = S_STOUT;
                end
                else
                begin
                    cmd.emit_rst = 1'b1;
                    state_next   = S_EMRD;
                end
            end
            S_EMRD:
            begin
                cmd.rd_sel = sphull_pkg::RD_EMIT;
                state_next = S_EMLD;
            end
            S_EMLD:
            begin
                cmd.out_ld_pt  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_EMOUT;
            end
            S_EMOUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (stat.emit_last)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cmd.emit_inc = 1'b1;
                        state_next   = S_EMRD;
                    end
                end
            end
            S_STOUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_COL;
            pair_top_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pair_top_reg  <= pair_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/simple_polygon_convex_hull_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// simple_polygon_convex_hull_core
// Online convex hull of a simple counter-clockwise polygon (deque method).
// ---------------------------------------------------------------------------
// one vertex at a time; orientation tests on deque points first read two points from the deque store
// every point trimmed from the deque costs one more orientation test
// final vertex: 2 closing tests, then one result per hull point
// no new vertex is taken while results are pending
// reset clears all run state; the deque store needs no clearing pass
module simple_polygon_convex_hull_core (
    input wire logic   clk,
    input wire logic   rst_n,
    sphull_vtx_if.sink   vertex,
    sphull_res_if.source result
);

    sphull_pkg::cmd_t  cmd;
    sphull_pkg::stat_t stat;

    sphull_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_ready  (vertex.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sphull_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_x        (vertex.point_x),
        .in_y        (vertex.point_y),
        .in_final    (vertex.final_vertex),
        .hull_x      (result.hull_x),
        .hull_y      (result.hull_y),
        .status      (result.status),
        .hull_size   (result.hull_size),
        .last_result (result.last_result)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/sphull_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphull_checker
// Port-level checks of the hull core, bound to the top level.
// ---------------------------------------------------------------------------
module sphull_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             vtx_ready,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic [sphull_pkg::COORD_BITS-1:0] hull_x,
    input wire logic [sphull_pkg::COORD_BITS-1:0] hull_y,
    input wire logic [1:0]                       status,
    input wire logic [sphull_pkg::SIZE_BITS-1:0] hull_size,
    input wire logic                             last_result
);

    // no vertex request is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !vtx_ready)
        else $error("vertex ready while result pending");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != sphull_pkg::ST_HULL) |-> last_result && hull_size == '0 &&
        hull_x == '0 && hull_y == '0)
        else $error("status result not a lone zeroed result");

    a_hull_size: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == sphull_pkg::ST_HULL) |-> hull_size >= 7'd2 &&
        hull_size <= 7'(sphull_pkg::MAX_VERTICES))
        else $error("hull size out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(hull_x) && $stable(status))
        else $error("stalled result changed");

endmodule

bind simple_polygon_convex_hull_core sphull_checker u_sphull_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .vtx_ready   (vertex.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .hull_x      (result.hull_x),
    .hull_y      (result.hull_y),
    .status      (result.status),
    .hull_size   (result.hull_size),
    .last_result (result.last_result)
);
`default_nettype wire
